// ===== design/lpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared constants, types and the sequencer state encoding.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
  localparam int FAULT_W    = 32;
  localparam int CFG_W      = 5;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;
  localparam int TREE_NODES = 2 * MAX_FRAMES - 1;
  localparam int TREE_W     = $clog2(TREE_NODES);

  localparam logic [FRAME_W-1:0] RANK_MAX      = FRAME_W'(MAX_FRAMES - 1);
  localparam logic [CFG_W-1:0]   FRAMES_RESET  = CFG_W'(4);
  // Register index of frames_in_use in the configuration space.
  localparam logic               REG_FRAMES    = 1'b0;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [FRAME_W-1:0]   frame_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_VICTIM,
    ST_UPDATE
  } lpr_state_e;

  // Strobes from the sequencer to the datapath of the back end.
  typedef struct packed {
    logic pop;
    logic lookup;
    logic victim;
    logic update;
  } lpr_ctrl_t;

endpackage

// ===== design/lpr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement channel interfaces
// Valid/ready channels for page references and replacement results.
// ----------------------------------------------------------------------------
interface lpr_in_if;
  logic           valid;
  logic           ready;
  lpr_pkg::page_t page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface lpr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  lpr_pkg::frame_t              frame;
  logic                         evicted_valid;
  lpr_pkg::page_t               evicted_page;
  logic [lpr_pkg::FAULT_W-1:0]  fault_count;

  modport source (output valid, output hit, output frame, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink   (input valid, input hit, input frame, input evicted_valid,
                  input evicted_page, input fault_count, output ready);
endinterface

// ===== design/lpr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement front end
// Accepts page references into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module lpr_front (
  input  logic clk_i,
  input  logic rst_ni,
  lpr_in_if.sink   in_if,
  lpr_in_if.source q_if
);
  import lpr_pkg::*;

  localparam int DEPTH = 2;

  page_t      buf_q [DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  // The queue takes a transfer whenever a slot is free.
  assign in_if.ready = (count_q != 2'(DEPTH));
  assign q_if.valid  = (count_q != 2'd0);
  assign q_if.page   = buf_q[rd_ptr_q];

  assign push = in_if.valid & in_if.ready;
  assign pop  = q_if.valid & q_if.ready;

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= in_if.page;
  end

endmodule

// ===== design/lpr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement back end
// Frame table, lookup, victim search, recency update and result register.
// ----------------------------------------------------------------------------
module lpr_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lpr_pkg::CFG_W-1:0] frames_in_use_i,
  lpr_in_if.sink                    q_if,
  lpr_out_if.source                 out_if
);
  import lpr_pkg::*;

  lpr_state_e state_q, state_d;
  lpr_ctrl_t  ctrl;

  // Frame table.
  logic              valid_q [MAX_FRAMES];
  page_t             page_q  [MAX_FRAMES];
  frame_t            rank_q  [MAX_FRAMES];
  logic [FAULT_W-1:0] faults_q;

  // Item being worked on.
  page_t  cur_page_q;
  logic   hit_q, found_q;
  frame_t idx_q;

  // Result register.
  logic               out_valid_q;
  logic               out_hit_q, out_ev_valid_q;
  frame_t             out_frame_q;
  page_t              out_ev_page_q;
  logic [FAULT_W-1:0] out_faults_q;

  // Clamp the frame count to one through MAX_FRAMES.
  logic [COUNT_W-1:0] n_eff;
  always_comb begin
    if (frames_in_use_i == '0) begin
      n_eff = COUNT_W'(1);
    end else if (frames_in_use_i > CFG_W'(MAX_FRAMES)) begin
      n_eff = COUNT_W'(MAX_FRAMES);
    end else begin
      n_eff = COUNT_W'(frames_in_use_i);
    end
  end

  logic active [MAX_FRAMES];
  always_comb begin
    for (int j = 0; j < MAX_FRAMES; j++) begin
      active[j] = (COUNT_W'(j) < n_eff);
    end
  end

  // Parallel lookup: lowest matching frame and lowest empty frame.
  logic   hit_c, found_c;
  frame_t hit_idx_c, empty_idx_c;
  always_comb begin
    hit_c       = 1'b0;
    found_c     = 1'b0;
    hit_idx_c   = '0;
    empty_idx_c = '0;
    for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
      if (active[j] && valid_q[j] && (page_q[j] == cur_page_q)) begin
        hit_c     = 1'b1;
        hit_idx_c = FRAME_W'(j);
      end
      if (active[j] && !valid_q[j]) begin
        found_c     = 1'b1;
        empty_idx_c = FRAME_W'(j);
      end
    end
  end

  // Oldest frame by a comparison tree; the left (lower) side wins a tie.
  // Frames outside the count carry key zero and always sit right of frame 0.
  logic [FRAME_W:0] tr_key [TREE_NODES];
  frame_t           tr_idx [TREE_NODES];
  always_comb begin
    for (int j = 0; j < MAX_FRAMES; j++) begin
      tr_key[MAX_FRAMES - 1 + j] = active[j] ? {1'b1, rank_q[j]} : '0;
      tr_idx[MAX_FRAMES - 1 + j] = FRAME_W'(j);
    end
    for (int i = MAX_FRAMES - 2; i >= 0; i--) begin
      if (tr_key[2*i+2] > tr_key[2*i+1]) begin
        tr_key[i] = tr_key[2*i+2];
        tr_idx[i] = tr_idx[2*i+2];
      end else begin
        tr_key[i] = tr_key[2*i+1];
        tr_idx[i] = tr_idx[2*i+1];
      end
    end
  end

  // Rank of the chosen frame before the update; an empty fill ages everyone.
  logic [FRAME_W:0] old_rank;
  assign old_rank = (!hit_q && found_q) ? (FRAME_W+1)'(MAX_FRAMES)
                                        : {1'b0, rank_q[idx_q]};

  logic ev_valid_c;
  assign ev_valid_c = !hit_q && !found_q;

  logic [FAULT_W-1:0] faults_next;
  assign faults_next = (!hit_q && (faults_q != '1)) ? faults_q + FAULT_W'(1) : faults_q;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_if.valid && (!out_valid_q || out_if.ready)) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = (hit_c || found_c) ? ST_UPDATE : ST_VICTIM;
      end
      ST_VICTIM: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer: strobes.
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE:   ctrl.pop    = q_if.valid && (!out_valid_q || out_if.ready);
      ST_LOOKUP: ctrl.lookup = 1'b1;
      ST_VICTIM: ctrl.victim = 1'b1;
      ST_UPDATE: ctrl.update = 1'b1;
      default:   ctrl = '0;
    endcase
  end

  assign q_if.ready = ctrl.pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk_i) begin
    if (ctrl.pop) cur_page_q <= q_if.page;
    if (ctrl.lookup) begin
      hit_q   <= hit_c;
      found_q <= found_c;
      idx_q   <= hit_c ? hit_idx_c : empty_idx_c;
    end else if (ctrl.victim) begin
      idx_q <= tr_idx[0];
    end
  end

  // Valid bits, recency ranks and fault counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_FRAMES; j++) begin
        valid_q[j] <= 1'b0;
        rank_q[j]  <= '0;
      end
      faults_q <= '0;
    end else if (ctrl.update) begin
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (FRAME_W'(j) == idx_q) begin
          rank_q[j] <= '0;
        end else if (active[j] && valid_q[j] && ({1'b0, rank_q[j]} < old_rank) &&
                     (rank_q[j] < RANK_MAX)) begin
          rank_q[j] <= rank_q[j] + FRAME_W'(1);
        end
      end
      if (!hit_q) valid_q[idx_q] <= 1'b1;
      faults_q <= faults_next;
    end
  end

  // Page numbers; only read while the frame's valid bit is set.
  always_ff @(posedge clk_i) begin
    if (ctrl.update && !hit_q) page_q[idx_q] <= cur_page_q;
  end

  // Result register: holds until the sink takes the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.update) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.update) begin
      out_hit_q      <= hit_q;
      out_frame_q    <= idx_q;
      out_ev_valid_q <= ev_valid_c;
      out_ev_page_q  <= ev_valid_c ? page_q[idx_q] : '0;
      out_faults_q   <= faults_next;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.hit           = out_hit_q;
  assign out_if.frame         = out_frame_q;
  assign out_if.evicted_valid = out_ev_valid_q;
  assign out_if.evicted_page  = out_ev_page_q;
  assign out_if.fault_count   = out_faults_q;

endmodule

// ===== design/lru_page_replacement_unit.sv =====
`timescale 1ns / 1ps
// A reference passes through the front-end queue and then the back-end states pop,
// lookup, victim search and update; a hit or an empty-frame fill skips the search.
// The single back-end sequencer that owns the frame table handles one reference at
// a time, while the front-end queue takes new references as long as a slot is free.
// Reset: frames empty, ranks and fault count zero, frames_in_use set to 4.
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Fully associative frame set with LRU replacement and an APB config port.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lpr_in_if.sink                     in_if,
  lpr_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lpr_pkg::APB_AW-1:0] paddr,
  input  logic [lpr_pkg::APB_DW-1:0] pwdata,
  output logic [lpr_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import lpr_pkg::*;

  logic [CFG_W-1:0] frames_in_use_q;
  logic             cfg_wr;

  // Configuration register; address 4 and above hold nothing.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_FRAMES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FRAMES_RESET;
    end else if (cfg_wr) begin
      frames_in_use_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_FRAMES) ? APB_DW'(frames_in_use_q) : '0;

  // Queue between the front and back ends.
  lpr_in_if q_if ();

  lpr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .q_if   (q_if.source)
  );

  lpr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frames_in_use_i (frames_in_use_q),
    .q_if            (q_if.sink),
    .out_if          (out_if)
  );

endmodule

// ===== tb/lru_page_replacement_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement unit testbench
// Sends page references over the input channel and programs frames_in_use
// over the APB port. A frame tracker class predicts hit, frame, eviction and
// fault count for each accepted reference and checks each result transfer
// against the oldest prediction. Both channel sides idle at random. The
// receiver also holds off for a long stretch so that the unit backs up.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit_tb;
  import lpr_pkg::*;

  // One result transfer, kept four-state so that unknown outputs are caught.
  typedef struct {
    logic                hit;
    logic [FRAME_W-1:0]  frame;
    logic                evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FAULT_W-1:0]  fault_count;
  } lookup_result_t;

  // Frame table predictor and the queue of results it still expects.
  class lru_frame_tracker;
    bit                   valid_q[MAX_FRAMES];
    page_t                page_q[MAX_FRAMES];
    bit [FRAME_W-1:0]     rank_q[MAX_FRAMES];
    bit [FAULT_W-1:0]     faults;
    bit [CFG_W-1:0]       frames_cfg;
    lookup_result_t       pending_results[$];
    int unsigned          errors;

    function new();
      foreach (valid_q[j]) begin
        valid_q[j] = 1'b0;
        page_q[j]  = '0;
        rank_q[j]  = '0;
      end
      faults     = '0;
      frames_cfg = FRAMES_RESET;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // The count is clamped to one frame at least and to the table size at most.
    function int unsigned active_frames();
      int unsigned n;
      n = frames_cfg;
      if (n < 1) n = 1;
      if (n > MAX_FRAMES) n = MAX_FRAMES;
      return n;
    endfunction

    // Frame x becomes most recent; valid frames newer than it age by one.
    function void promote(int unsigned n, int unsigned x, int unsigned old_rank);
      for (int unsigned j = 0; j < n; j++) begin
        if (j != x && valid_q[j] && rank_q[j] < old_rank && rank_q[j] < RANK_MAX)
          rank_q[j]++;
      end
      rank_q[x] = '0;
    endfunction

    // Predicts the outcome of one accepted reference.
    function void note_reference(page_t pg);
      int unsigned    n;
      int unsigned    x;
      int unsigned    best;
      bit             hit;
      bit             found;
      lookup_result_t r;
      n     = active_frames();
      x     = 0;
      hit   = 1'b0;
      found = 1'b0;
      r.evicted_valid = 1'b0;
      r.evicted_page  = '0;
      // The lowest matching index wins when several frames hold the page.
      for (int unsigned j = 0; j < n && !hit; j++) begin
        if (valid_q[j] && page_q[j] == pg) begin
          hit = 1'b1;
          x   = j;
        end
      end
      if (hit) begin
        promote(n, x, rank_q[x]);
      end else begin
        if (faults != '1) faults++;
        for (int unsigned j = 0; j < n && !found; j++) begin
          if (!valid_q[j]) begin
            found = 1'b1;
            x     = j;
          end
        end
        if (found) begin
          promote(n, x, MAX_FRAMES);
          valid_q[x] = 1'b1;
        end else begin
          // Oldest frame in use, lowest index on a tie.
          best = rank_q[0];
          x    = 0;
          for (int unsigned j = 1; j < n; j++) begin
            if (rank_q[j] > best) begin
              best = rank_q[j];
              x    = j;
            end
          end
          r.evicted_valid = 1'b1;
          r.evicted_page  = page_q[x];
          promote(n, x, rank_q[x]);
        end
        page_q[x] = pg;
      end
      r.hit         = hit;
      r.frame       = frame_t'(x);
      r.fault_count = faults;
      pending_results.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // Compares one result transfer with the oldest prediction.
    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with no reference outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      field_check("hit", want.hit, got.hit);
      field_check("frame", want.frame, got.frame);
      field_check("evicted_valid", want.evicted_valid, got.evicted_valid);
      field_check("evicted_page", want.evicted_page, got.evicted_page);
      field_check("fault_count", want.fault_count, got.fault_count);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  lpr_in_if  in_ch ();
  lpr_out_if out_ch ();

  lru_page_replacement_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch.sink),
    .out_if  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lru_frame_tracker tracker = new();

  int unsigned src_idle_pct  = 15;
  int unsigned sink_idle_pct = 54;
  bit          stall_request = 1'b0;
  page_t       hot_pages[24];
  int unsigned hot_count     = 4;

  // Clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: checks each result transfer and chooses ready for the next edge.
  initial begin
    int unsigned    hold_left;
    lookup_result_t got;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready) begin
        got.hit           = out_ch.hit;
        got.frame         = out_ch.frame;
        got.evicted_valid = out_ch.evicted_valid;
        got.evicted_page  = out_ch.evicted_page;
        got.fault_count   = out_ch.fault_count;
        tracker.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_request) begin
        stall_request = 1'b0;
        hold_left     = 200;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Offers one page and returns at the edge of its transfer; valid stays high.
  task automatic send_page(input page_t pg);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.page  <= pg;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.note_reference(pg);
  endtask

  // Stops offering and waits until every result is back and the unit is idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Writes frames_in_use, then reads it back.
  task automatic program_frames(input logic [CFG_W-1:0] count);
    for (int rd = 0; rd < 2; rd++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (rd == 0);
      paddr   <= APB_AW'(int'(REG_FRAMES) * 4);
      pwdata  <= APB_DW'(count);
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (rd == 1)
        tracker.field_check("frames_in_use", APB_DW'(count), prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
    end
    tracker.frames_cfg = count;
  endtask

  // Mostly a small working set near the frame count, some full-range pages.
  function automatic page_t pick_page();
    if ($urandom_range(99) < 85) return hot_pages[$urandom_range(hot_count - 1)];
    return page_t'($urandom);
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] count, input int unsigned items,
                           input bit long_stall);
    settle();
    program_frames(count);
    hot_count = tracker.active_frames() + $urandom_range(1, 4);
    foreach (hot_pages[j]) hot_pages[j] = page_t'($urandom);
    hot_pages[0] = '0;
    hot_pages[1] = '1;
    if (long_stall) stall_request = 1'b1;
    for (int unsigned k = 0; k < items; k++) send_page(pick_page());
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.page  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // Reset count of four: empty fills, hits, then LRU eviction.
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h1234);
    send_page(16'h0000);
    send_page(16'hABCD);
    send_page(16'h5555);
    send_page(16'h0000);
    send_page(16'hFFFF);

    // Shrinking the count hides a resident page, which then gets loaded a
    // second time; growing it back leaves two frames holding the same page.
    settle();
    program_frames(CFG_W'(2));
    send_page(16'hABCD);
    settle();
    program_frames(CFG_W'(4));
    send_page(16'hABCD);

    // A single frame in use.
    settle();
    program_frames(CFG_W'(1));
    send_page(16'h0001);
    send_page(16'h0001);
    send_page(16'h0002);

    // A count of zero acts as one frame.
    settle();
    program_frames(CFG_W'(0));
    send_page(16'h0003);
    send_page(16'h0003);

    // A count above the table size acts as the whole table.
    settle();
    program_frames(CFG_W'(31));
    send_page(16'h8000);
    send_page(16'h7FFF);
    send_page(16'h0003);
    send_page(16'hFFFE);
    send_page(16'h8000);
    send_page(16'h0000);

    // Random references under several frame counts and idling patterns.
    src_idle_pct  = 15;
    sink_idle_pct = 54;
    run_phase(CFG_W'(1), 100, 1'b0);
    run_phase(CFG_W'(16), 100, 1'b1);
    src_idle_pct  = 54;
    sink_idle_pct = 15;
    run_phase(CFG_W'(0), 100, 1'b0);
    run_phase(CFG_W'(31), 100, 1'b1);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_phase(CFG_W'($urandom_range(1, 16)), 100, 1'b0);
    run_phase(CFG_W'($urandom_range(0, 31)), 100, 1'b1);

    settle();
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
